FILE: src/ktp_pkg.sv
// ============================================================================
// ktp_pkg
// Shared widths, codes and types for the top-k closest pair tracker.
// ============================================================================
package ktp_pkg;

  // Field widths
  localparam int COORD_W = 16;
  localparam int ID_W    = 32;
  localparam int DIST_W  = 35;
  localparam int SQ_W    = 32;
  localparam int ACT_W   = 2;
  localparam int TOPC_W  = 5;
  localparam int RANK_W  = 4;

  // Packed beat widths
  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 104;

  // Defaults
  localparam int LIST_DEPTH_DEF = 16;
  localparam logic [TOPC_W-1:0] TOP_COUNT_RESET = 5'd16;

  // Saturation limit of the distance accumulator
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Action codes
  localparam logic [ACT_W-1:0] ACT_COORD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // One list entry
  typedef struct packed {
    logic [ID_W-1:0]   idb;
    logic [ID_W-1:0]   ida;
    logic [DIST_W-1:0] sq_dist;
  } entry_t;

  // Status of the square stage, seen by the controller
  typedef struct packed {
    logic             valid;
    logic [ACT_W-1:0] action;
    logic             last;
  } stage_t;

  // Command to the cell row
  typedef struct packed {
    logic cmp;
    logic commit;
    logic rotate;
  } cell_cmd_t;

  // Clamp a requested count into 1..depth
  function automatic int eff_count(input logic [TOPC_W-1:0] tc, input int depth);
    int k;
    k = int'(tc);
    if (k < 1) k = 1;
    if (k > depth) k = depth;
    return k;
  endfunction

endpackage

FILE: src/ktp_accum.sv
// ============================================================================
// ktp_accum
// Squares the coordinate difference of each beat and accumulates the pair's
// squared distance with saturation.
// ============================================================================
module ktp_accum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [ktp_pkg::ACT_W-1:0]   action,
  input  logic [ktp_pkg::COORD_W-1:0] a_coord,
  input  logic [ktp_pkg::COORD_W-1:0] b_coord,
  input  logic                        last_coord,
  input  logic [ktp_pkg::ID_W-1:0]    a_id,
  input  logic [ktp_pkg::ID_W-1:0]    b_id,
  output ktp_pkg::stage_t             stat,
  output ktp_pkg::entry_t             pair
);

  logic signed [ktp_pkg::COORD_W:0] diff;
  logic [ktp_pkg::COORD_W-1:0]      mag;
  logic                             s1_valid;
  logic [ktp_pkg::ACT_W-1:0]        s1_action;
  logic                             s1_last;
  logic [ktp_pkg::SQ_W-1:0]         s1_sq;
  logic [ktp_pkg::ID_W-1:0]         s1_a_id;
  logic [ktp_pkg::ID_W-1:0]         s1_b_id;
  logic [ktp_pkg::DIST_W-1:0]       acc;
  logic [ktp_pkg::DIST_W:0]         sum;
  logic [ktp_pkg::DIST_W-1:0]       sat;

  // Difference and magnitude of the incoming coordinates
  always_comb begin
    diff = $signed({a_coord[ktp_pkg::COORD_W-1], a_coord})
         - $signed({b_coord[ktp_pkg::COORD_W-1], b_coord});
    if (diff < 0) begin
      mag = ktp_pkg::COORD_W'(-diff);
    end else begin
      mag = ktp_pkg::COORD_W'(diff);
    end
  end

  // Square stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
    if (take) begin
      s1_action <= action;
      s1_last   <= last_coord;
      s1_sq     <= mag * mag;
      s1_a_id   <= a_id;
      s1_b_id   <= b_id;
    end
  end

  // Saturating sum
  always_comb begin
    sum = {1'b0, acc} + (ktp_pkg::DIST_W+1)'(s1_sq);
    sat = sum[ktp_pkg::DIST_W] ? ktp_pkg::DIST_MAX : sum[ktp_pkg::DIST_W-1:0];
  end

  // Accumulate, and restart on the pair's last coordinate
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s1_valid && s1_action == ktp_pkg::ACT_COORD) begin
      acc <= s1_last ? '0 : sat;
    end
  end

  assign stat.valid   = s1_valid;
  assign stat.action  = s1_action;
  assign stat.last    = s1_last;
  assign pair.sq_dist = sat;
  assign pair.ida     = s1_a_id;
  assign pair.idb     = s1_b_id;

endmodule

FILE: src/ktp_cell.sv
// ============================================================================
// ktp_cell
// One slot of the sorted list: compares the offered pair against its entry,
// shifts from its left neighbor on insert and from its right on readout.
// ============================================================================
module ktp_cell #(
  parameter int IDX    = 0,
  parameter int FILL_W = 5
) (
  input  logic               clk,
  input  ktp_pkg::cell_cmd_t cmd,
  input  ktp_pkg::entry_t    offer,
  input  ktp_pkg::entry_t    head,
  input  ktp_pkg::entry_t    left_entry,
  input  logic               left_go,
  input  ktp_pkg::entry_t    right_entry,
  input  logic               dup,
  input  logic [FILL_W-1:0]  fill,
  input  logic [FILL_W-1:0]  k,
  output ktp_pkg::entry_t    entry,
  output logic               go,
  output logic               match
);

  logic occupied;
  logic in_range;
  logic tail;

  assign occupied = FILL_W'(IDX) < fill;
  assign in_range = FILL_W'(IDX) < k;
  assign tail     = FILL_W'(IDX + 1) == fill;

  // Record where the offer lands and whether it repeats this entry
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      go    <= ~occupied | (offer.sq_dist < entry.sq_dist);
      match <= occupied & (offer == entry);
    end
  end

  // Insert or shift right; on readout rotate toward the head
  always_ff @(posedge clk) begin
    if (cmd.commit && !dup && in_range) begin
      if (left_go) begin
        entry <= left_entry;
      end else if (go) begin
        entry <= offer;
      end
    end else if (cmd.rotate && occupied) begin
      entry <= tail ? head : right_entry;
    end
  end

endmodule

FILE: src/top_k_closest_pair_tracker.sv
// ============================================================================
// top_k_closest_pair_tracker
// Accumulates squared distances of point pairs and keeps the closest ones in
// a sorted row of cells.
// ============================================================================
// Coordinate beats that are not a pair's last are taken one per cycle while
// no pair, clear or readout is in progress. The last coordinate of a pair
// holds the input through square, accumulate, compare in every cell at once,
// then insert and shift along the cell row; a pair at distance zero is
// skipped before the compare. A clear holds the input while it passes the
// square stage and empties the list. A readout gives one beat per list entry
// (one for an empty list), with the list rotating through the cell row so
// that each beat comes from the head cell; the input stays held until the
// last entry has been loaded into the output register. Output backpressure
// stretches the readout beat for beat. Results carry squared distance in Q35.0.
module top_k_closest_pair_tracker #(
  parameter int LIST_DEPTH = ktp_pkg::LIST_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration: top_count
  input  logic                          cfg_wen,
  input  logic [ktp_pkg::TOPC_W-1:0]    cfg_wdata,
  // Input beats
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // a_coord[15:0], b_coord[31:16], a_id[63:32], b_id[95:64]
  input  logic [ktp_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // action[1:0]
  input  logic [ktp_pkg::ACT_W-1:0]     s_axis_tuser,
  input  logic                          s_axis_tlast,
  // Result beats
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // sq_distance[34:0], first_id[66:35], second_id[98:67], rank[102:99], pad
  output logic [ktp_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // entry_valid[0]
  output logic [0:0]                    m_axis_tuser,
  output logic                          m_axis_tlast
);

  localparam int FILL_W = $clog2(LIST_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CMP    = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_READ   = 4'b1000
  } state_t;

  state_t                       state;
  state_t                       state_next;
  ktp_pkg::stage_t              stat;
  ktp_pkg::entry_t              pair;
  ktp_pkg::entry_t              offer;
  ktp_pkg::cell_cmd_t           cmd;
  ktp_pkg::entry_t              cell_entry [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]        go_vec;
  logic [LIST_DEPTH-1:0]        match_vec;
  logic                         dup;
  logic [ktp_pkg::TOPC_W-1:0]   top_count;
  logic [FILL_W-1:0]            fill;
  logic [FILL_W-1:0]            k;
  logic [FILL_W-1:0]            k_new;
  logic [FILL_W-1:0]            rd_idx;
  logic                         accept;
  logic                         s1_block;
  logic                         pair_done;
  logic                         step;
  logic                         step_last;
  ktp_pkg::entry_t              out_entry;
  logic [ktp_pkg::RANK_W-1:0]   out_rank;
  logic                         out_valid;
  logic                         out_last;

  // Input handshake: hold while a pair, clear or readout is in progress
  assign s1_block = stat.valid && (stat.action != ktp_pkg::ACT_COORD || stat.last);
  assign s_axis_tready = (state == ST_IDLE) && !s1_block;
  assign accept = s_axis_tvalid && s_axis_tready;

  ktp_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .take       (accept),
    .action     (s_axis_tuser),
    .a_coord    (s_axis_tdata[15:0]),
    .b_coord    (s_axis_tdata[31:16]),
    .last_coord (s_axis_tlast),
    .a_id       (s_axis_tdata[63:32]),
    .b_id       (s_axis_tdata[95:64]),
    .stat       (stat),
    .pair       (pair)
  );

  assign pair_done = stat.valid && stat.action == ktp_pkg::ACT_COORD && stat.last;

  assign k     = FILL_W'(ktp_pkg::eff_count(top_count, LIST_DEPTH));
  assign k_new = FILL_W'(ktp_pkg::eff_count(cfg_wdata, LIST_DEPTH));

  // Readout advances when the output register is free
  assign step      = (state == ST_READ) && (!m_axis_tvalid || m_axis_tready);
  assign step_last = (fill == '0) || (rd_idx + FILL_W'(1) == fill);

  assign cmd.cmp    = (state == ST_CMP);
  assign cmd.commit = (state == ST_COMMIT);
  assign cmd.rotate = step && (fill != '0);

  assign dup = |match_vec;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pair_done && pair.sq_dist != '0) begin
          state_next = ST_CMP;
        end else if (stat.valid && stat.action == ktp_pkg::ACT_READ) begin
          state_next = ST_READ;
        end
      end
      ST_CMP: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_next = ST_IDLE;
      end
      ST_READ: begin
        if (step && step_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the finished pair for the cell row
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pair_done) begin
      offer <= pair;
    end
  end

  // Register, fill count and readout position
  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= ktp_pkg::TOP_COUNT_RESET;
      fill      <= '0;
      rd_idx    <= '0;
    end else begin
      if (cfg_wen) begin
        top_count <= cfg_wdata;
        if (fill > k_new) begin
          fill <= k_new;
        end
      end else if (stat.valid && stat.action == ktp_pkg::ACT_CLEAR) begin
        fill <= '0;
      end else if (cmd.commit && !dup && fill < k) begin
        fill <= fill + FILL_W'(1);
      end
      if (step) begin
        rd_idx <= step_last ? '0 : rd_idx + FILL_W'(1);
      end
    end
  end

  // Row of list cells
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    ktp_pkg::entry_t left_entry;
    ktp_pkg::entry_t right_entry;
    logic            left_go;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_go    = 1'b0;
    end else begin : g_inner
      assign left_entry = cell_entry[i-1];
      assign left_go    = go_vec[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_end
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    ktp_cell #(
      .IDX    (i),
      .FILL_W (FILL_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .offer       (offer),
      .head        (cell_entry[0]),
      .left_entry  (left_entry),
      .left_go     (left_go),
      .right_entry (right_entry),
      .dup         (dup),
      .fill        (fill),
      .k           (k),
      .entry       (cell_entry[i]),
      .go          (go_vec[i]),
      .match       (match_vec[i])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (step) begin
      out_last <= step_last;
      if (fill == '0) begin
        out_entry <= '0;
        out_rank  <= '0;
        out_valid <= 1'b0;
      end else begin
        out_entry <= cell_entry[0];
        out_rank  <= ktp_pkg::RANK_W'(rd_idx);
        out_valid <= 1'b1;
      end
    end
  end

  assign m_axis_tdata = {1'b0, out_rank, out_entry.idb, out_entry.ida, out_entry.sq_dist};
  assign m_axis_tuser = out_valid;
  assign m_axis_tlast = out_last;

endmodule

FILE: bench/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the top-k closest pair tracker.
// ============================================================================
// Drives point-pair coordinate, readout and clear beats into the stream input.
// A predictor in the bench keeps its own copy of the distance accumulator and
// the sorted pair list, and queues the result beats that every readout should
// give. A checker compares each output beat, field by field, with the oldest
// queued result. The sender idles in random bursts and the receiver stalls on
// its own pattern, with one long receiver hold that backs up the block. The
// list size register is swept across its extremes between traffic phases.
// ============================================================================
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                         LIST_DEPTH  = 16;
  localparam logic [ktp_pkg::ACT_W-1:0]  ACT_NONE    = 2'd3;
  localparam int                         CYCLE_LIMIT = 200000;
  localparam int                         SETTLE      = 16;
  localparam int                         HOLD_CYCLES = 400;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // One expected result beat of a readout
  typedef struct packed {
    logic [ktp_pkg::DIST_W-1:0] sq_dist;
    logic [ktp_pkg::ID_W-1:0]   ida;
    logic [ktp_pkg::ID_W-1:0]   idb;
    logic [ktp_pkg::RANK_W-1:0] rank;
    logic                       valid;
    logic                       last;
  } list_beat_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_wen;
  logic [ktp_pkg::TOPC_W-1:0]   cfg_wdata;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [ktp_pkg::S_DATA_W-1:0] s_axis_tdata;
  logic [ktp_pkg::ACT_W-1:0]    s_axis_tuser;
  logic                         s_axis_tlast;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [ktp_pkg::M_DATA_W-1:0] m_axis_tdata;
  logic [0:0]                   m_axis_tuser;
  logic                         m_axis_tlast;

  // Predictor state
  logic [ktp_pkg::TOPC_W-1:0]   model_top;
  logic [ktp_pkg::DIST_W-1:0]   model_acc;
  logic [ktp_pkg::DIST_W-1:0]   list_dist [LIST_DEPTH];
  logic [ktp_pkg::ID_W-1:0]     list_ida  [LIST_DEPTH];
  logic [ktp_pkg::ID_W-1:0]     list_idb  [LIST_DEPTH];
  int                           list_fill;

  list_beat_t                   readout_queue[$];

  // Bench bookkeeping
  int       mismatches;
  int       beats_sent;
  int       noise_beats;
  int       results_seen;
  int       settings_used;
  int       cycle_count;
  int       burst_left;
  bit       tx_gaps;
  rx_mode_t rx_mode;
  int       hold_request;

  top_k_closest_pair_tracker #(.LIST_DEPTH(LIST_DEPTH)) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a run that stops making progress
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, readout_queue.size());
      $display("[top_k_closest_pair_tracker] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int kept_limit();
    int k;
    k = int'(model_top);
    if (k < 1) k = 1;
    if (k > LIST_DEPTH) k = LIST_DEPTH;
    return k;
  endfunction

  function automatic void apply_top_count(input logic [ktp_pkg::TOPC_W-1:0] v);
    model_top = v;
    if (list_fill > kept_limit()) list_fill = kept_limit();
  endfunction

  // Insert a finished pair into the sorted list
  function automatic void offer_to_list(input logic [ktp_pkg::DIST_W-1:0] d,
                                        input logic [ktp_pkg::ID_W-1:0] ia,
                                        input logic [ktp_pkg::ID_W-1:0] ib);
    int k;
    int pos;
    int i;
    k = kept_limit();
    if (d == '0) return;
    if (list_fill > k) list_fill = k;
    pos = 0;
    while (pos < list_fill) begin
      if (d < list_dist[pos]) break;
      if (d == list_dist[pos] && ia == list_ida[pos] && ib == list_idb[pos]) return;
      pos++;
    end
    if (pos >= k) return;
    i = (list_fill < k) ? list_fill : k - 1;
    while (i > pos) begin
      list_dist[i] = list_dist[i-1];
      list_ida[i]  = list_ida[i-1];
      list_idb[i]  = list_idb[i-1];
      i--;
    end
    list_dist[pos] = d;
    list_ida[pos]  = ia;
    list_idb[pos]  = ib;
    if (list_fill < k) list_fill++;
  endfunction

  // Advance the predictor by one accepted input beat
  function automatic void predict_beat(input logic [ktp_pkg::ACT_W-1:0] act,
                                       input logic [ktp_pkg::COORD_W-1:0] ac,
                                       input logic [ktp_pkg::COORD_W-1:0] bc,
                                       input logic lst,
                                       input logic [ktp_pkg::ID_W-1:0] ia,
                                       input logic [ktp_pkg::ID_W-1:0] ib);
    int              diff;
    longint unsigned mag;
    longint unsigned total;
    int              n;
    list_beat_t      b;
    case (act)
      ktp_pkg::ACT_COORD: begin
        diff  = int'($signed(ac)) - int'($signed(bc));
        mag   = (diff < 0) ? longint'(-diff) : longint'(diff);
        total = longint'(model_acc) + mag * mag;
        if (total > longint'(ktp_pkg::DIST_MAX)) total = longint'(ktp_pkg::DIST_MAX);
        model_acc = total[ktp_pkg::DIST_W-1:0];
        if (lst) begin
          offer_to_list(model_acc, ia, ib);
          model_acc = '0;
        end
      end
      ktp_pkg::ACT_READ: begin
        n = (list_fill < kept_limit()) ? list_fill : kept_limit();
        if (n == 0) begin
          b = '0;
          b.last = 1'b1;
          readout_queue = {readout_queue, b};
        end else begin
          for (int r = 0; r < n; r++) begin
            b.sq_dist = list_dist[r];
            b.ida     = list_ida[r];
            b.idb     = list_idb[r];
            b.rank    = ktp_pkg::RANK_W'(r);
            b.valid   = 1'b1;
            b.last    = (r == n - 1);
            readout_queue = {readout_queue, b};
          end
        end
      end
      ktp_pkg::ACT_CLEAR: begin
        list_fill = 0;
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    $display("mismatch on result %0d, %s: got %0h, want %0h",
             results_seen, field, got, want);
  endtask

  // Compare each output beat with the oldest queued result
  always @(posedge clk) begin : check_results
    list_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (readout_queue.size() == 0) begin
        report_mismatch("unexpected beat", 64'(m_axis_tdata[34:0]), 64'(0));
      end else begin
        want = readout_queue.pop_front();
        if (m_axis_tdata[34:0] != want.sq_dist)
          report_mismatch("sq_distance", 64'(m_axis_tdata[34:0]), 64'(want.sq_dist));
        if (m_axis_tdata[66:35] != want.ida)
          report_mismatch("first_id", 64'(m_axis_tdata[66:35]), 64'(want.ida));
        if (m_axis_tdata[98:67] != want.idb)
          report_mismatch("second_id", 64'(m_axis_tdata[98:67]), 64'(want.idb));
        if (m_axis_tdata[102:99] != want.rank)
          report_mismatch("rank", 64'(m_axis_tdata[102:99]), 64'(want.rank));
        if (m_axis_tuser[0] != want.valid)
          report_mismatch("entry_valid", 64'(m_axis_tuser[0]), 64'(want.valid));
        if (m_axis_tlast != want.last)
          report_mismatch("last_entry", 64'(m_axis_tlast), 64'(want.last));
      end
      results_seen++;
    end
  end

  // Receiver: stall on its own pattern, with an occasional long hold
  initial begin : drive_ready
    int phase;
    int holds_done;
    int hold_left;
    phase      = 0;
    holds_done = 0;
    hold_left  = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      phase++;
      if (hold_request != holds_done) begin
        hold_left  = HOLD_CYCLES;
        holds_done = hold_request;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  m_axis_tready <= 1'b1;
          RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
          default:    m_axis_tready <= ((phase % 7) < 4);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic idle_gap(input int n);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Offer one beat and hold it until accepted
  task automatic send_beat(input logic [ktp_pkg::ACT_W-1:0] act,
                           input logic [ktp_pkg::COORD_W-1:0] ac,
                           input logic [ktp_pkg::COORD_W-1:0] bc, input logic lst,
                           input logic [ktp_pkg::ID_W-1:0] ia,
                           input logic [ktp_pkg::ID_W-1:0] ib);
    if (tx_gaps && burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      idle_gap($urandom_range(1, 6));
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ib, ia, bc, ac};
    s_axis_tuser  <= act;
    s_axis_tlast  <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_beat(act, ac, bc, lst, ia, ib);
    if (act == ACT_NONE) noise_beats++;
    else beats_sent++;
  endtask

  task automatic send_coord(input logic [ktp_pkg::COORD_W-1:0] ac,
                            input logic [ktp_pkg::COORD_W-1:0] bc,
                            input logic lst, input logic [ktp_pkg::ID_W-1:0] ia,
                            input logic [ktp_pkg::ID_W-1:0] ib);
    send_beat(ktp_pkg::ACT_COORD, ac, bc, lst, ia, ib);
  endtask

  // Readout, clear or unused code, carrying random payload
  task automatic send_cmd(input logic [ktp_pkg::ACT_W-1:0] act);
    send_beat(act, ktp_pkg::COORD_W'($urandom), ktp_pkg::COORD_W'($urandom),
              1'($urandom), $urandom, $urandom);
  endtask

  // Drop valid, wait for every queued result, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (readout_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_top_count(input logic [ktp_pkg::TOPC_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    apply_top_count(v);
    @(negedge clk);
    cfg_wen   <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [ktp_pkg::ID_W-1:0] pick_id();
    logic [ktp_pkg::ID_W-1:0] pool [3];
    pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_A5A5};
    if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 2)];
    return $urandom;
  endfunction

  // Send one pair; style 0 wide, 1 near (ties, duplicates), 2 identical,
  // 3 extreme coordinates
  task automatic send_pair(input int dims, input int style,
                           input logic [ktp_pkg::ID_W-1:0] ia,
                           input logic [ktp_pkg::ID_W-1:0] ib);
    logic [ktp_pkg::COORD_W-1:0] ac;
    logic [ktp_pkg::COORD_W-1:0] bc;
    int                          v;
    for (int c = 0; c < dims; c++) begin
      case (style)
        0: begin
          ac = ktp_pkg::COORD_W'($urandom);
          bc = ktp_pkg::COORD_W'($urandom);
        end
        1: begin
          v  = $urandom_range(0, 6);
          ac = ktp_pkg::COORD_W'(v - 3);
          v  = $urandom_range(0, 6);
          bc = ktp_pkg::COORD_W'(v - 3);
        end
        2: begin
          ac = ktp_pkg::COORD_W'($urandom);
          bc = ac;
        end
        default: begin
          ac = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
          bc = ~ac;
        end
      endcase
      // Break into a pair in progress now and then
      if (c > 0 && $urandom_range(0, 19) == 0) send_cmd(ktp_pkg::ACT_READ);
      send_coord(ac, bc, c == dims - 1, ia, ib);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Empty list, zero distance, ties, duplicates, unused code, readout and
  // clear in the middle of a pair, saturation, id extremes
  task automatic test_directed_cases();
    rx_mode = RX_ALWAYS;
    tx_gaps = 1'b0;
    send_cmd(ktp_pkg::ACT_READ);
    send_coord(16'h1234, 16'h1234, 1'b1, 32'd5, 32'd6);
    send_coord(16'h7FFF, 16'h8000, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    send_coord(16'h0001, 16'h0000, 1'b0, 32'd0, 32'd0);
    send_coord(16'h0000, 16'h0001, 1'b1, 32'd1, 32'd2);
    send_coord(16'h0001, 16'h0000, 1'b0, 32'd0, 32'd0);
    send_coord(16'h0000, 16'h0001, 1'b1, 32'd1, 32'd2);
    send_coord(16'hFFFF, 16'h0000, 1'b0, 32'd0, 32'd0);
    send_coord(16'h0000, 16'hFFFF, 1'b1, 32'd3, 32'd4);
    send_beat(ACT_NONE, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_coord(16'h0400, 16'h0000, 1'b0, 32'd0, 32'd0);
    send_cmd(ktp_pkg::ACT_READ);
    send_coord(16'h0000, 16'h0000, 1'b1, 32'd7, 32'd8);
    send_cmd(ktp_pkg::ACT_READ);
    // Saturating pair of nine extreme coordinates, cleared list midway
    for (int c = 0; c < 9; c++) begin
      if (c == 4) begin
        send_cmd(ktp_pkg::ACT_CLEAR);
        send_cmd(ktp_pkg::ACT_READ);
      end
      send_coord(16'h8000, 16'h7FFF, c == 8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    end
    send_cmd(ktp_pkg::ACT_READ);
  endtask

  // Shrink the list size below its fill, then widen it again
  task automatic test_top_count_cut();
    rx_mode = RX_PATTERN;
    tx_gaps = 1'b1;
    write_top_count(5'd16);
    for (int i = 1; i <= 6; i++)
      send_coord(ktp_pkg::COORD_W'(i), 16'h0000, 1'b1, ktp_pkg::ID_W'(i),
                 ktp_pkg::ID_W'(i + 100));
    send_cmd(ktp_pkg::ACT_READ);
    write_top_count(5'd3);
    send_cmd(ktp_pkg::ACT_READ);
    write_top_count(5'd1);
    send_coord(16'h0000, 16'h0000, 1'b1, 32'd9, 32'd9);
    send_coord(16'h0100, 16'h0000, 1'b1, 32'd9, 32'd9);
    send_cmd(ktp_pkg::ACT_READ);
    write_top_count(5'd16);
    send_cmd(ktp_pkg::ACT_READ);
  endtask

  // Fill the list, hold the receiver off while readouts pile up, then drain
  task automatic test_long_stall();
    rx_mode = RX_ALWAYS;
    tx_gaps = 1'b0;
    write_top_count(5'd16);
    send_cmd(ktp_pkg::ACT_CLEAR);
    for (int i = 1; i <= 16; i++)
      send_coord(ktp_pkg::COORD_W'(17 - i), 16'h0000, 1'b1, ktp_pkg::ID_W'(i), $urandom);
    hold_request++;
    repeat (3) send_cmd(ktp_pkg::ACT_READ);
    send_pair(2, 0, pick_id(), pick_id());
    send_cmd(ktp_pkg::ACT_READ);
    wait_idle();
  endtask

  // Random traffic across several list sizes
  task automatic test_random_traffic();
    logic [ktp_pkg::TOPC_W-1:0] sizes [7];
    int                         start;
    int                         pick;
    sizes = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4,
              ktp_pkg::TOPC_W'($urandom_range(1, 16)), 5'd16};
    foreach (sizes[s]) begin
      write_top_count(sizes[s]);
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      tx_gaps = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) != 0) send_cmd(ktp_pkg::ACT_CLEAR);
      start = beats_sent;
      while (beats_sent - start < 36) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)
          send_pair(($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4),
                    $urandom_range(0, 3), pick_id(), pick_id());
        else if (pick < 88)
          send_cmd(ktp_pkg::ACT_READ);
        else if (pick < 93)
          send_cmd(ktp_pkg::ACT_CLEAR);
        else if (pick < 96)
          send_cmd(ACT_NONE);
        else
          send_coord(ktp_pkg::COORD_W'($urandom), ktp_pkg::COORD_W'($urandom), 1'b0,
                     $urandom, $urandom);
      end
      send_cmd(ktp_pkg::ACT_READ);
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst           = 1'b1;
    cfg_wen       = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    rx_mode       = RX_ALWAYS;
    tx_gaps       = 1'b0;
    hold_request  = 0;
    burst_left    = 0;
    beats_sent    = 0;
    noise_beats   = 0;
    settings_used = 0;
    model_acc     = '0;
    list_fill     = 0;
    model_top     = ktp_pkg::TOP_COUNT_RESET;
    foreach (list_dist[i]) begin
      list_dist[i] = '0;
      list_ida[i]  = '0;
      list_idb[i]  = '0;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_top_count_cut();
    test_long_stall();
    test_random_traffic();
    wait_idle();

    $display("run covered %0d input beats (%0d unused-code beats), %0d result beats,",
             beats_sent, noise_beats, results_seen);
    $display("%0d list size writes, one long receiver hold, %0d mismatches",
             settings_used, mismatches);
    if (mismatches == 0 && readout_queue.size() == 0) begin
      $display("[top_k_closest_pair_tracker] OK");
    end else begin
      $display("[top_k_closest_pair_tracker] ERROR");
    end
    $finish;
  end

endmodule

FILE: top_k_closest_pair_tracker.f
src/ktp_pkg.sv
src/ktp_accum.sv
src/ktp_cell.sv
src/top_k_closest_pair_tracker.sv
bench/tb_top.sv
